// File: rtl/core/mbfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_pkg
// Shared types and codes for the message batch frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfc_pkg;

  // Parser position within a frame
  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COUNT   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TAIL    = 3'd4,
    PH_DEAD    = 3'd5
  } phase_t;

  // Verdict codes
  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_TOO_SHORT   = 3'd1,
    ERR_BAD_VERSION = 3'd2,
    ERR_ZERO_COUNT  = 3'd3,
    ERR_TRUNCATED   = 3'd4,
    ERR_MISMATCH    = 3'd5
  } err_t;

  localparam logic [7:0] VERSION_RESET = 8'd1;
  localparam logic [1:0] MIN_FRAME_BYTES = 2'd3;
  localparam logic [1:0] HDR_LAST_INDEX = 2'd3;

  // One frame byte as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One verdict
  typedef struct packed {
    logic frame_ok;
    err_t error_code;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/mbfc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_in_reg
// Input register: captures one request and holds it until the parser advances.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_byte,
  input  wire logic            advance,
  output logic                 item_vld,
  output mbfc_pkg::item_t      item
);

  logic            vld_r;
  logic            vld_nxt;
  logic            load;
  mbfc_pkg::item_t item_r;

  // Stall while a held request cannot move on
  assign in_stall = vld_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// File: rtl/core/mbfc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_parse
// Frame parser: holds the frame state, folds in one byte per advance and
// forms the verdict for a byte marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfc_parse #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic            advance,
  input  wire mbfc_pkg::item_t item,
  output mbfc_pkg::result_t    result
);

  logic [7:0]             version_r;
  mbfc_pkg::phase_t       phase_r,     phase_nxt;
  logic [1:0]             fbc_r,       fbc_nxt;
  logic [7:0]             msgs_r,      msgs_nxt;
  logic [1:0]             hdr_idx_r,   hdr_idx_nxt;
  logic [LENGTH_BITS-1:0] acc_r,       acc_nxt;
  logic [LENGTH_BITS-1:0] pay_r,       pay_nxt;
  logic                   bad_ver_r,   bad_ver_nxt;
  mbfc_pkg::err_t         lerr_r,      lerr_nxt;
  logic [31:0]            hdr_word;
  logic [LENGTH_BITS-1:0] pay_dec;
  mbfc_pkg::err_t         code;
  logic [7:0]             b;

  assign b = item.data_byte;

  // Merge a header byte at its little-endian position
  always_comb begin
    hdr_word = (hdr_idx_r == 2'd0) ? 32'd0 : 32'(acc_r);
    hdr_word = hdr_word | (32'(b) << {hdr_idx_r, 3'b000});
  end

  assign pay_dec = pay_r - LENGTH_BITS'(1);

  // Advance the frame state by one byte
  always_comb begin
    phase_nxt   = phase_r;
    fbc_nxt     = (fbc_r < mbfc_pkg::MIN_FRAME_BYTES) ? fbc_r + 2'd1 : fbc_r;
    msgs_nxt    = msgs_r;
    hdr_idx_nxt = hdr_idx_r;
    acc_nxt     = acc_r;
    pay_nxt     = pay_r;
    bad_ver_nxt = bad_ver_r;
    lerr_nxt    = lerr_r;
    unique case (phase_r)
      mbfc_pkg::PH_VERSION: begin
        if (b != version_r) begin
          bad_ver_nxt = 1'b1;
        end
        phase_nxt = mbfc_pkg::PH_COUNT;
      end
      mbfc_pkg::PH_COUNT: begin
        if (b == 8'd0) begin
          lerr_nxt  = mbfc_pkg::ERR_ZERO_COUNT;
          phase_nxt = mbfc_pkg::PH_DEAD;
        end else begin
          msgs_nxt    = b;
          hdr_idx_nxt = 2'd0;
          acc_nxt     = '0;
          phase_nxt   = mbfc_pkg::PH_HEADER;
        end
      end
      mbfc_pkg::PH_HEADER: begin
        if (hdr_idx_r == 2'd0) begin
          msgs_nxt = msgs_r - 8'd1;
        end
        acc_nxt = hdr_word[LENGTH_BITS-1:0];
        if (hdr_idx_r == mbfc_pkg::HDR_LAST_INDEX) begin
          hdr_idx_nxt = 2'd0;
          pay_nxt     = hdr_word[LENGTH_BITS-1:0];
          if (hdr_word[LENGTH_BITS-1:0] == '0) begin
            phase_nxt = (msgs_nxt != 8'd0) ? mbfc_pkg::PH_HEADER : mbfc_pkg::PH_TAIL;
          end else begin
            phase_nxt = mbfc_pkg::PH_PAYLOAD;
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + 2'd1;
        end
      end
      mbfc_pkg::PH_PAYLOAD: begin
        pay_nxt = pay_dec;
        if (pay_dec == '0) begin
          phase_nxt = (msgs_r != 8'd0) ? mbfc_pkg::PH_HEADER : mbfc_pkg::PH_TAIL;
        end
      end
      mbfc_pkg::PH_TAIL: begin
        lerr_nxt = mbfc_pkg::ERR_MISMATCH;
      end
      default: begin
      end
    endcase
  end

  // Verdict on the state after this byte
  always_comb begin
    if (fbc_nxt < mbfc_pkg::MIN_FRAME_BYTES) begin
      code = mbfc_pkg::ERR_TOO_SHORT;
    end else if (bad_ver_nxt) begin
      code = mbfc_pkg::ERR_BAD_VERSION;
    end else if (lerr_nxt != mbfc_pkg::ERR_OK) begin
      code = lerr_nxt;
    end else if (phase_nxt == mbfc_pkg::PH_TAIL) begin
      code = mbfc_pkg::ERR_OK;
    end else if (phase_nxt == mbfc_pkg::PH_PAYLOAD && msgs_nxt == 8'd0) begin
      code = mbfc_pkg::ERR_MISMATCH;
    end else begin
      code = mbfc_pkg::ERR_TRUNCATED;
    end
  end

  assign result.frame_ok   = (code == mbfc_pkg::ERR_OK);
  assign result.error_code = code;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= mbfc_pkg::VERSION_RESET;
    end else if (cfg_wr_en) begin
      version_r <= cfg_wr_data;
    end
  end

  // Frame state: update per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && item.last_byte)) begin
      phase_r   <= mbfc_pkg::PH_VERSION;
      fbc_r     <= 2'd0;
      msgs_r    <= 8'd0;
      hdr_idx_r <= 2'd0;
      acc_r     <= '0;
      pay_r     <= '0;
      bad_ver_r <= 1'b0;
      lerr_r    <= mbfc_pkg::ERR_OK;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      fbc_r     <= fbc_nxt;
      msgs_r    <= msgs_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      acc_r     <= acc_nxt;
      pay_r     <= pay_nxt;
      bad_ver_r <= bad_ver_nxt;
      lerr_r    <= lerr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mbfc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_out_reg
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire mbfc_pkg::result_t result,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_frame_ok,
  output logic [2:0]             out_error_code
);

  logic              vld_r;
  logic              vld_nxt;
  mbfc_pkg::result_t res_r;

  // Free when empty or being taken this cycle
  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r && out_stall;
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid      = vld_r;
  assign out_frame_ok   = res_r.frame_ok;
  assign out_error_code = res_r.error_code;

endmodule

`default_nettype wire

// File: rtl/core/message_batch_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_batch_frame_checker_top
// Checks a framed batch of length-prefixed messages, one byte per request.
//
// Input channel (in_*): one frame byte per request, in_last_byte marks the
// final byte. Result channel (out_*): one verdict per frame, issued for the
// last byte only; out_frame_ok is high when out_error_code is zero.
// Configuration: cfg_wr_en writes cfg_wr_data as the expected version byte.
// Throughput: one byte per cycle while the result register can take each
// verdict. Each byte goes through the input register and the parser update;
// a verdict then moves into the result register and shows on out_valid once
// the result register has loaded it.
// Stall: a held result does not block bytes that produce no result; a second
// last byte waits in the input register while the result register is full
// and stalled, and only then does in_stall rise.
// Reset: clears both registers and the frame state; the expected version
// returns to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module message_batch_frame_checker_top #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_frame_ok,
  output logic [2:0]      out_error_code
);

  logic              item_vld;
  mbfc_pkg::item_t   item;
  logic              advance;
  logic              out_free;
  mbfc_pkg::result_t result;

  // Move a byte on unless it carries a verdict with nowhere to go
  assign advance = item_vld && (!item.last_byte || out_free);

  mbfc_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_vld     (item_vld),
    .item         (item)
  );

  mbfc_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .result      (result)
  );

  mbfc_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && item.last_byte),
    .result         (result),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_ok   (out_frame_ok),
    .out_error_code (out_error_code)
  );

endmodule

`default_nettype wire

// File: rtl/core/mbfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_checker
// Port-level assertions for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_last_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_frame_ok,
  input wire logic [2:0] out_error_code
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_error_code) && $stable(out_frame_ok))
    else $error("stalled result changed");

  // Pass flag agrees with the code
  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_ok == (out_error_code == mbfc_pkg::ERR_OK)))
    else $error("frame_ok disagrees with error_code");

  // Code stays in its defined range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code <= mbfc_pkg::ERR_MISMATCH))
    else $error("error_code out of range");

  // A fresh result follows an accepted last byte
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte, 2))
    else $error("result without a last byte");

endmodule

bind message_batch_frame_checker_top mbfc_checker u_mbfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_ok   (out_frame_ok),
  .out_error_code (out_error_code)
);

`default_nettype wire

// File: tb/tb_message_batch_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_batch_frame_checker_top
// Self-checking bench for the message batch frame checker. Frames are built
// as byte requests (short directed frames, then random well-formed, cut,
// padded and corrupted frames), sent with random gaps against a receiver
// that stalls in random bursts. A frame model predicts each verdict and
// every returned verdict is compared field by field. Expected-version writes
// go in between frames once all verdicts have come back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_message_batch_frame_checker_top;

  localparam int LEN_BITS    = 32;
  localparam int NUM_BYTES   = 650;
  localparam int CALM_BYTES  = 80;
  localparam int SETTLE      = 6;
  localparam int DRAIN       = 20;
  localparam int STUCK_LIMIT = 2000;
  localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_BITS);

  typedef logic [7:0] byte_q_t[$];

  // One pending request, or a version write
  typedef struct {
    logic        is_cfg;
    logic [7:0]  data;
    logic        last;
    int unsigned hold;
  } pend_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_frame_ok;
  logic [2:0] out_error_code;

  pend_t             byte_q[$];
  mbfc_pkg::result_t verdict_q[$];

  // Frame model state
  logic [7:0]       model_version;
  mbfc_pkg::phase_t m_phase;
  logic [1:0]       m_count;
  logic [7:0]       m_msgs;
  logic [1:0]       m_hidx;
  logic [31:0]      m_len;
  logic [31:0]      m_left;
  logic             m_badver;
  mbfc_pkg::err_t   m_err;

  int err_count;
  int bytes_sent;
  int verdicts_seen;
  int cfg_writes;
  int since_input;
  int stall_left;
  int mon_cycles;
  int stuck;
  int queued;
  int verdict_hist[8];

  message_batch_frame_checker_top #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_ok  (out_frame_ok),
    .out_error_code(out_error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string what);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Return the frame model to its idle state
  task automatic clear_frame_model();
    m_phase  = mbfc_pkg::PH_VERSION;
    m_count  = 2'd0;
    m_msgs   = 8'd0;
    m_hidx   = 2'd0;
    m_len    = 32'd0;
    m_left   = 32'd0;
    m_badver = 1'b0;
    m_err    = mbfc_pkg::ERR_OK;
  endtask

  task automatic end_message();
    if (m_msgs != 8'd0) begin
      m_phase = mbfc_pkg::PH_HEADER;
    end else begin
      m_phase = mbfc_pkg::PH_TAIL;
    end
  endtask

  // Advance the frame model by one accepted byte; queue a verdict on the last
  task automatic parse_frame_byte(input logic [7:0] b, input logic last);
    mbfc_pkg::err_t    code;
    mbfc_pkg::result_t r;
    if (m_count < mbfc_pkg::MIN_FRAME_BYTES) m_count++;
    case (m_phase)
      mbfc_pkg::PH_VERSION: begin
        if (b != model_version) m_badver = 1'b1;
        m_phase = mbfc_pkg::PH_COUNT;
      end
      mbfc_pkg::PH_COUNT: begin
        if (b == 8'd0) begin
          m_err   = mbfc_pkg::ERR_ZERO_COUNT;
          m_phase = mbfc_pkg::PH_DEAD;
        end else begin
          m_msgs  = b;
          m_hidx  = 2'd0;
          m_len   = 32'd0;
          m_phase = mbfc_pkg::PH_HEADER;
        end
      end
      mbfc_pkg::PH_HEADER: begin
        if (m_hidx == 2'd0) begin
          m_msgs--;
          m_len = 32'd0;
        end
        m_len = m_len | ({24'd0, b} << (8 * m_hidx));
        if (m_hidx == mbfc_pkg::HDR_LAST_INDEX) begin
          m_hidx = 2'd0;
          m_left = m_len & LEN_MASK;
          if (m_left == 32'd0) begin
            end_message();
          end else begin
            m_phase = mbfc_pkg::PH_PAYLOAD;
          end
        end else begin
          m_hidx++;
        end
      end
      mbfc_pkg::PH_PAYLOAD: begin
        m_left--;
        if (m_left == 32'd0) end_message();
      end
      mbfc_pkg::PH_TAIL: m_err = mbfc_pkg::ERR_MISMATCH;
      default: ;
    endcase
    if (last) begin
      if (m_count < mbfc_pkg::MIN_FRAME_BYTES) begin
        code = mbfc_pkg::ERR_TOO_SHORT;
      end else if (m_badver) begin
        code = mbfc_pkg::ERR_BAD_VERSION;
      end else if (m_err != mbfc_pkg::ERR_OK) begin
        code = m_err;
      end else if (m_phase == mbfc_pkg::PH_TAIL) begin
        code = mbfc_pkg::ERR_OK;
      end else if (m_phase == mbfc_pkg::PH_PAYLOAD && m_msgs == 8'd0) begin
        code = mbfc_pkg::ERR_MISMATCH;
      end else begin
        code = mbfc_pkg::ERR_TRUNCATED;
      end
      r.frame_ok   = (code == mbfc_pkg::ERR_OK);
      r.error_code = code;
      verdict_q.push_back(r);
      clear_frame_model();
    end
  endtask

  // Pick the sender gap ahead of the next request
  function automatic int unsigned pick_hold();
    if (queued >= NUM_BYTES - CALM_BYTES) return 0;
    if ((queued / 60) % 4 == 1) return 0;
    if ($urandom_range(0, 6) == 0) return $urandom_range(1, 11);
    return 0;
  endfunction

  task automatic queue_frame(input byte_q_t fb);
    pend_t p;
    foreach (fb[i]) begin
      p.is_cfg = 1'b0;
      p.data   = fb[i];
      p.last   = (i == fb.size() - 1);
      p.hold   = pick_hold();
      byte_q.push_back(p);
      queued++;
    end
  endtask

  task automatic queue_version(input logic [7:0] v);
    pend_t p;
    p.is_cfg = 1'b1;
    p.data   = v;
    p.last   = 1'b0;
    p.hold   = 0;
    byte_q.push_back(p);
  endtask

  // Append a well-formed batch of cnt messages with small lengths
  task automatic add_messages(ref byte_q_t fb, input int cnt);
    int unsigned len;
    for (int m = 0; m < cnt; m++) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(7, 24);
      end else begin
        len = $urandom_range(0, 6);
      end
      fb.push_back(len[7:0]);
      fb.push_back(8'd0);
      fb.push_back(8'd0);
      fb.push_back(8'd0);
      for (int k = 0; k < len; k++) fb.push_back(8'($urandom));
    end
  endtask

  // Build one random frame: mostly well formed, the rest cut, padded or corrupt
  task automatic build_frame(ref byte_q_t fb, input logic [7:0] ver);
    int roll;
    int cnt;
    int cut;
    roll = $urandom_range(0, 99);
    fb.delete();
    if (roll < 70) begin
      cnt = $urandom_range(1, 4);
      fb.push_back((roll >= 55 && roll < 61) ? (ver ^ 8'($urandom_range(1, 255))) : ver);
      fb.push_back(8'(cnt));
      add_messages(fb, cnt);
      if (roll >= 40 && roll < 50) begin
        // cut anywhere inside the frame
        cut = $urandom_range(1, fb.size() - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end else if (roll >= 50 && roll < 55) begin
        // pad past the last payload
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
      end
    end else if (roll < 77) begin
      fb.push_back(ver);
      fb.push_back(8'd0);
      repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
    end else if (roll < 83) begin
      repeat ($urandom_range(1, 2)) fb.push_back(8'($urandom));
    end else if (roll < 92) begin
      fb.push_back($urandom_range(0, 1) ? ver : 8'($urandom));
      repeat ($urandom_range(2, 13)) fb.push_back(8'($urandom));
    end else begin
      // long count, then stop early, possibly inside a huge length header
      cnt = $urandom_range(5, 255);
      fb.push_back(ver);
      fb.push_back(8'(cnt));
      add_messages(fb, $urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
        repeat ($urandom_range(0, 5)) fb.push_back(8'($urandom));
      end
    end
  endtask

  // Sender: hold a stalled request, else issue the next one from the queue
  always @(posedge clk) begin
    pend_t nxt;
    logic  cfg_en_nxt;
    cfg_en_nxt = 1'b0;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'd0;
      in_last_byte <= 1'b0;
      since_input  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_frame_byte(in_data_byte, in_last_byte);
        bytes_sent++;
        since_input = 0;
      end else begin
        since_input++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          nxt = byte_q.pop_front();
          if (nxt.is_cfg) begin
            // wait until every verdict is back and the pipeline has settled
            in_valid <= 1'b0;
            if (since_input >= SETTLE && verdict_q.size() == 0) begin
              cfg_en_nxt    = 1'b1;
              cfg_wr_data   <= nxt.data;
              model_version = nxt.data;
              cfg_writes++;
            end else begin
              byte_q.push_front(nxt);
            end
          end else if (nxt.hold != 0) begin
            nxt.hold--;
            byte_q.push_front(nxt);
            in_valid <= 1'b0;
          end else begin
            in_valid     <= 1'b1;
            in_data_byte <= nxt.data;
            in_last_byte <= nxt.last;
          end
        end
      end
    end
    cfg_wr_en <= cfg_en_nxt;
  end

  // Receiver: check each accepted verdict, stall in random bursts
  always @(posedge clk) begin
    mbfc_pkg::result_t want;
    logic              stall_nxt;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      mon_cycles = 0;
    end else begin
      mon_cycles++;
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report_error($sformatf("verdict code %0d with no frame outstanding",
                                 out_error_code));
        end else begin
          want = verdict_q.pop_front();
          verdict_hist[want.error_code]++;
          if (out_frame_ok !== want.frame_ok) begin
            report_error($sformatf("frame_ok %b, expected %b", out_frame_ok,
                                   want.frame_ok));
          end
          if (out_error_code !== want.error_code) begin
            report_error($sformatf("error_code %0d, expected %0d", out_error_code,
                                   want.error_code));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end else if (byte_q.size() > CALM_BYTES && (mon_cycles % 256) >= 64 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        stall_nxt  = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      out_stall <= stall_nxt;
    end
  end

  // Abort when no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STUCK_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    byte_q_t     fb;
    logic [7:0]  cur_ver;
    int          next_cfg;
    model_version = mbfc_pkg::VERSION_RESET;
    cur_ver       = mbfc_pkg::VERSION_RESET;
    clear_frame_model();

    // Directed frames at the reset version
    queue_frame('{8'h01, 8'h02});
    queue_frame('{8'h7E, 8'h01, 8'h00});
    queue_frame('{8'h01, 8'h00, 8'hAA});
    queue_frame('{8'h01, 8'h02, 8'h05});
    queue_frame('{8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA});
    // Version at its top value: maximal count, and an early end in the payload
    queue_version(8'hFF);
    cur_ver = 8'hFF;
    queue_frame('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    queue_frame('{8'hFF, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h55});
    queue_version(8'h00);
    cur_ver = 8'h00;

    // Random frames with occasional version changes between them
    next_cfg = queued + 130;
    while (queued < NUM_BYTES) begin
      if (queued >= next_cfg) begin
        cur_ver = 8'($urandom);
        queue_version(cur_ver);
        next_cfg = queued + 130;
      end
      build_frame(fb, cur_ver);
      queue_frame(fb);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all requests to go in and all verdicts to come out
    @(negedge clk);
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d frame bytes, checked %0d verdicts, %0d version writes",
             bytes_sent, verdicts_seen, cfg_writes);
    $display("Verdicts: ok %0d, short %0d, version %0d, zero %0d, truncated %0d, %s %0d",
             verdict_hist[mbfc_pkg::ERR_OK], verdict_hist[mbfc_pkg::ERR_TOO_SHORT],
             verdict_hist[mbfc_pkg::ERR_BAD_VERSION],
             verdict_hist[mbfc_pkg::ERR_ZERO_COUNT],
             verdict_hist[mbfc_pkg::ERR_TRUNCATED], "length error",
             verdict_hist[mbfc_pkg::ERR_MISMATCH]);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
